[sv/binary_min_heap_queue_top_assert.svh]
// Assertion macros for the heap queue.
`ifndef BINARY_MIN_HEAP_QUEUE_TOP_ASSERT_SVH
`define BINARY_MIN_HEAP_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BMHQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("heap queue assertion failed");

// Next-cycle implication, checked outside reset.
`define BMHQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("heap queue assertion failed");

`endif

[sv/bmhq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bmhq_pkg;

  localparam int CapacityDef = 256;
  localparam int TagBitsDef  = 16;

  localparam int KEY_W    = 31;
  localparam int TAG_IO_W = 16;
  localparam int ACT_W    = 3;
  localparam int POS_W    = 8;
  localparam int STAT_W   = 3;
  localparam int CNT_IO_W = 9;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT   = 3'd0,
    ACT_EXTRACT  = 3'd1,
    ACT_PEEK     = 3'd2,
    ACT_DECREASE = 3'd3,
    ACT_DELETE   = 3'd4
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_FULL   = 3'd2,
    ST_BADPOS = 3'd3,
    ST_RAISED = 3'd4
  } status_e;

endpackage

`default_nettype wire

[sv/bmhq_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

// Single-port-write, single-port-read RAM with a registered read.
module bmhq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[sv/bmhq_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

// Heap sequencer: runs each action as a series of RAM reads and writes,
// moving a hole through the tree instead of swapping entries.
module bmhq_ctrl #(
  parameter int Capacity = bmhq_pkg::CapacityDef,
  parameter int TagBits  = bmhq_pkg::TagBitsDef,
  localparam int IDX_W   = $clog2(Capacity),
  localparam int CNT_W   = $clog2(Capacity + 1),
  localparam int ENT_W   = bmhq_pkg::KEY_W + TagBits
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [bmhq_pkg::ACT_W-1:0]    action_i,
  input  wire logic [bmhq_pkg::KEY_W-1:0]    key_in_i,
  input  wire logic [bmhq_pkg::TAG_IO_W-1:0] tag_in_i,
  input  wire logic [bmhq_pkg::POS_W-1:0]    position_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [bmhq_pkg::KEY_W-1:0]         key_out_o,
  output logic [bmhq_pkg::TAG_IO_W-1:0]      tag_out_o,
  output logic [bmhq_pkg::STAT_W-1:0]        status_o,
  output logic [bmhq_pkg::CNT_IO_W-1:0]      entry_count_o,
  output logic                               mem_we_o,
  output logic [IDX_W-1:0]                   mem_waddr_o,
  output logic [ENT_W-1:0]                   mem_wdata_o,
  output logic                               mem_re_o,
  output logic [IDX_W-1:0]                   mem_raddr_o,
  input  wire logic [ENT_W-1:0]              mem_rdata_i
);

  localparam int KW   = bmhq_pkg::KEY_W;
  localparam int LR_W = IDX_W + 2;
  localparam int PC_W = (CNT_W > bmhq_pkg::POS_W) ? CNT_W : bmhq_pkg::POS_W;

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_UP_ISSUE, S_UP_CMP, S_LAST,
    S_DN_ISSUE_L, S_DN_ISSUE_R, S_DN_CMP, S_FIN, S_DONE
  } state_e;

  state_e                  state_q, state_d;
  bmhq_pkg::action_e       op_q, op_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic [KW-1:0]           ek_q, ek_d, lk_q, lk_d, res_key_q, res_key_d;
  logic [TagBits-1:0]      et_q, et_d, lt_q, lt_d, res_tag_q, res_tag_d;
  logic                    force_q, force_d, rhave_q, rhave_d;
  bmhq_pkg::status_e       res_st_q, res_st_d;
  logic                    out_valid_q, out_valid_d;
  logic [KW-1:0]           out_key_q, out_key_d;
  logic [TagBits-1:0]      out_tag_q, out_tag_d;
  bmhq_pkg::status_e       out_st_q, out_st_d;
  logic [CNT_W-1:0]        out_cnt_q, out_cnt_d;
  logic [KW-1:0]           in_key_q, in_key_d;

  logic [KW-1:0]           rd_key;
  logic [TagBits-1:0]      rd_tag;
  logic [IDX_W-1:0]        parent;
  logic [LR_W-1:0]         lidx, ridx, cnt_ext;
  logic [PC_W-1:0]         pos_ext;
  logic [CNT_W-1:0]        cnt_dec;

  assign rd_key  = mem_rdata_i[ENT_W-1:TagBits];
  assign rd_tag  = mem_rdata_i[TagBits-1:0];
  assign parent  = IDX_W'((idx_q - 1'b1) >> 1);
  assign lidx    = {1'b0, idx_q, 1'b1};
  assign ridx    = lidx + 1'b1;
  assign cnt_ext = LR_W'(cnt_q);
  assign pos_ext = PC_W'(position_i);
  assign cnt_dec = cnt_q - 1'b1;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    ek_d        = ek_q;
    et_d        = et_q;
    lk_d        = lk_q;
    lt_d        = lt_q;
    force_d     = force_q;
    rhave_d     = rhave_q;
    res_key_d   = res_key_q;
    res_tag_d   = res_tag_q;
    res_st_d    = res_st_q;
    in_key_d    = in_key_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_key_d   = out_key_q;
    out_tag_d   = out_tag_q;
    out_st_d    = out_st_q;
    out_cnt_d   = out_cnt_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q;
    mem_wdata_o = {ek_q, et_q};
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    in_ready_o  = (state_q == S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d      = bmhq_pkg::action_e'(action_i);
          in_key_d  = key_in_i;
          force_d   = 1'b0;
          res_key_d = '0;
          res_tag_d = '0;
          res_st_d  = bmhq_pkg::ST_OK;
          state_d   = S_DONE;
          case (action_i)
            bmhq_pkg::ACT_INSERT: begin
              if (cnt_q == CNT_W'(Capacity)) begin
                res_st_d = bmhq_pkg::ST_FULL;
              end else begin
                ek_d      = key_in_i;
                et_d      = TagBits'(tag_in_i);
                res_key_d = key_in_i;
                res_tag_d = TagBits'(tag_in_i);
                idx_d     = cnt_q[IDX_W-1:0];
                cnt_d     = cnt_q + 1'b1;
                state_d   = S_UP_ISSUE;
              end
            end
            bmhq_pkg::ACT_EXTRACT, bmhq_pkg::ACT_PEEK: begin
              if (cnt_q == '0) begin
                res_st_d = bmhq_pkg::ST_EMPTY;
              end else begin
                mem_re_o = 1'b1;
                state_d  = S_RD0;
              end
            end
            bmhq_pkg::ACT_DECREASE, bmhq_pkg::ACT_DELETE: begin
              if (cnt_q == '0) begin
                res_st_d = bmhq_pkg::ST_EMPTY;
              end else if (pos_ext >= PC_W'(cnt_q)) begin
                res_st_d = bmhq_pkg::ST_BADPOS;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = pos_ext[IDX_W-1:0];
                idx_d       = pos_ext[IDX_W-1:0];
                state_d     = S_RD0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RD0: begin
        res_key_d = rd_key;
        res_tag_d = rd_tag;
        state_d   = S_DONE;
        case (op_q)
          bmhq_pkg::ACT_EXTRACT: begin
            cnt_d = cnt_dec;
            if (cnt_dec != '0) begin
              mem_re_o    = 1'b1;
              mem_raddr_o = cnt_dec[IDX_W-1:0];
              state_d     = S_LAST;
            end
          end
          bmhq_pkg::ACT_DECREASE: begin
            if (in_key_q > rd_key) begin
              res_key_d = '0;
              res_tag_d = '0;
              res_st_d  = bmhq_pkg::ST_RAISED;
            end else begin
              res_key_d = in_key_q;
              ek_d      = in_key_q;
              et_d      = rd_tag;
              state_d   = S_UP_ISSUE;
            end
          end
          bmhq_pkg::ACT_DELETE: begin
            force_d = 1'b1;
            state_d = S_UP_ISSUE;
          end
          default: begin
          end
        endcase
      end
      S_UP_ISSUE: begin
        if (idx_q == '0) begin
          if (force_q) begin
            // Deleted entry sits at the root now; remove it like an extract.
            cnt_d   = cnt_dec;
            state_d = S_DONE;
            if (cnt_dec != '0) begin
              mem_re_o    = 1'b1;
              mem_raddr_o = cnt_dec[IDX_W-1:0];
              state_d     = S_LAST;
            end
          end else begin
            state_d = S_FIN;
          end
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = parent;
          state_d     = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (force_q || (ek_q < rd_key)) begin
          mem_we_o    = 1'b1;
          mem_wdata_o = mem_rdata_i;
          idx_d       = parent;
          state_d     = S_UP_ISSUE;
        end else begin
          state_d = S_FIN;
        end
      end
      S_LAST: begin
        ek_d    = rd_key;
        et_d    = rd_tag;
        idx_d   = '0;
        state_d = S_DN_ISSUE_L;
      end
      S_DN_ISSUE_L: begin
        if (lidx >= cnt_ext) begin
          state_d = S_FIN;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = lidx[IDX_W-1:0];
          state_d     = S_DN_ISSUE_R;
        end
      end
      S_DN_ISSUE_R: begin
        lk_d    = rd_key;
        lt_d    = rd_tag;
        rhave_d = (ridx < cnt_ext);
        if (ridx < cnt_ext) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = ridx[IDX_W-1:0];
        end
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (rhave_q) begin
          if ((ek_q <= lk_q) && (ek_q <= rd_key)) begin
            state_d = S_FIN;
          end else if (lk_q < rd_key) begin
            mem_we_o    = 1'b1;
            mem_wdata_o = {lk_q, lt_q};
            idx_d       = lidx[IDX_W-1:0];
            state_d     = S_DN_ISSUE_L;
          end else begin
            mem_we_o    = 1'b1;
            mem_wdata_o = mem_rdata_i;
            idx_d       = ridx[IDX_W-1:0];
            state_d     = S_DN_ISSUE_L;
          end
        end else if (ek_q <= lk_q) begin
          state_d = S_FIN;
        end else begin
          mem_we_o    = 1'b1;
          mem_wdata_o = {lk_q, lt_q};
          idx_d       = lidx[IDX_W-1:0];
          state_d     = S_DN_ISSUE_L;
        end
      end
      S_FIN: begin
        mem_we_o = 1'b1;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_key_d   = res_key_q;
          out_tag_d   = res_tag_q;
          out_st_d    = res_st_q;
          out_cnt_d   = cnt_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    idx_q     <= idx_d;
    ek_q      <= ek_d;
    et_q      <= et_d;
    lk_q      <= lk_d;
    lt_q      <= lt_d;
    force_q   <= force_d;
    rhave_q   <= rhave_d;
    res_key_q <= res_key_d;
    res_tag_q <= res_tag_d;
    res_st_q  <= res_st_d;
    in_key_q  <= in_key_d;
    out_key_q <= out_key_d;
    out_tag_q <= out_tag_d;
    out_st_q  <= out_st_d;
    out_cnt_q <= out_cnt_d;
  end

  assign out_valid_o   = out_valid_q;
  assign key_out_o     = out_key_q;
  assign tag_out_o     = bmhq_pkg::TAG_IO_W'(out_tag_q);
  assign status_o      = out_st_q;
  assign entry_count_o = bmhq_pkg::CNT_IO_W'(out_cnt_q);

endmodule

`default_nettype wire

[sv/binary_min_heap_queue_top.sv]
// Binary min-heap priority queue.
// The input channel (in_valid_i/in_ready_o) takes one item per request:
// an action (insert, extract minimum, peek, decrease key, delete at a
// position) with a key, a tag and a heap position. The output channel
// (out_valid_o/out_ready_i) returns exactly one item per request: the key
// and tag of the affected entry, a status code and the entry count after
// the action. Errors (empty, full, bad position, key raised) leave the heap
// unchanged and return zero key and tag.
// One item is worked on at a time. The heap lives in a single RAM with a
// registered read, and the work is paced by its single read port: each
// level of sift-up reads the parent and compares, each level of sift-down
// reads the left child, then the right child if there is one, then compares.
// A delete first carries its entry up to the root, then removes it like an extract.
// A finished item waits in an output register, so the next item may be
// accepted while the receiver stalls; a further result then holds until
// the register frees. Reset empties the heap at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

`include "binary_min_heap_queue_top_assert.svh"

module binary_min_heap_queue_top #(
  parameter int Capacity = bmhq_pkg::CapacityDef,
  parameter int TagBits  = bmhq_pkg::TagBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [bmhq_pkg::ACT_W-1:0]    action_i,
  input  wire logic [bmhq_pkg::KEY_W-1:0]    key_in_i,
  input  wire logic [bmhq_pkg::TAG_IO_W-1:0] tag_in_i,
  input  wire logic [bmhq_pkg::POS_W-1:0]    position_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [bmhq_pkg::KEY_W-1:0]         key_out_o,
  output logic [bmhq_pkg::TAG_IO_W-1:0]      tag_out_o,
  output logic [bmhq_pkg::STAT_W-1:0]        status_o,
  output logic [bmhq_pkg::CNT_IO_W-1:0]      entry_count_o
);

  localparam int IDX_W = $clog2(Capacity);
  localparam int ENT_W = bmhq_pkg::KEY_W + TagBits;

  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [ENT_W-1:0] mem_wdata, mem_rdata;

  // Each RAM word holds one entry: key in the upper bits, tag below.
  bmhq_ram #(
    .Width(ENT_W),
    .Depth(Capacity)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  bmhq_ctrl #(
    .Capacity(Capacity),
    .TagBits (TagBits)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .key_in_i     (key_in_i),
    .tag_in_i     (tag_in_i),
    .position_i   (position_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .key_out_o    (key_out_o),
    .tag_out_o    (tag_out_o),
    .status_o     (status_o),
    .entry_count_o(entry_count_o),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  // The sequencer never reads and writes one entry in the same cycle.
  `BMHQ_ASSERT_IMP(a_no_rw_clash, clk_i, rst_ni, mem_we && mem_re, mem_waddr != mem_raddr)
  // While waiting for a new item the heap memory is left alone.
  `BMHQ_ASSERT_IMP(a_idle_no_write, clk_i, rst_ni, in_ready_o, !mem_we)
  // An empty report always comes with a zero count.
  `BMHQ_ASSERT_IMP(a_empty_count, clk_i, rst_ni,
                   out_valid_o && (status_o == bmhq_pkg::ST_EMPTY), entry_count_o == '0)
  // Accepting an item starts work, so the block is busy in the next cycle.
  `BMHQ_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

endmodule

`default_nettype wire

[tb/binary_min_heap_queue_top_tb.sv]
`timescale 1ns / 1ps

module binary_min_heap_queue_top_tb;
  import bmhq_pkg::*;

  localparam int HeapDepth = 256;
  localparam int StallLimit = 20000;

  // One row of the directed table. When has_exp is set, the typed-in status,
  // key, tag and count must match the predictor as well as the block.
  typedef struct {
    logic [ACT_W-1:0]    act;
    logic [KEY_W-1:0]    key;
    logic [TAG_IO_W-1:0] tag;
    logic [POS_W-1:0]    pos;
    bit                  has_exp;
    status_e             exp_st;
    logic [KEY_W-1:0]    exp_key;
    logic [TAG_IO_W-1:0] exp_tag;
    logic [CNT_IO_W-1:0] exp_cnt;
  } heap_row_t;

  typedef struct {
    logic [KEY_W-1:0]    key;
    logic [TAG_IO_W-1:0] tag;
    logic [STAT_W-1:0]   st;
    logic [CNT_IO_W-1:0] cnt;
  } heap_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ACT_W-1:0]    action = '0;
  logic [KEY_W-1:0]    key_in = '0;
  logic [TAG_IO_W-1:0] tag_in = '0;
  logic [POS_W-1:0]    position = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [KEY_W-1:0]    key_out;
  logic [TAG_IO_W-1:0] tag_out;
  logic [STAT_W-1:0]   status;
  logic [CNT_IO_W-1:0] entry_count;

  always #6 clk = ~clk;

  binary_min_heap_queue_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .action_i(action), .key_in_i(key_in), .tag_in_i(tag_in), .position_i(position),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .key_out_o(key_out), .tag_out_o(tag_out), .status_o(status),
    .entry_count_o(entry_count)
  );

  // Shadow copy of the heap, kept in step with every accepted item.
  logic [KEY_W-1:0]    heap_key [HeapDepth];
  logic [TAG_IO_W-1:0] heap_tag [HeapDepth];
  int unsigned heap_fill;

  heap_result_t pending_results[$];
  int mismatches;
  int results_seen;
  int idle_cycles;
  bit long_hold;
  bit timed_out;
  int status_hits [8];

  function automatic void swap_nodes(int unsigned a, int unsigned b);
    logic [KEY_W-1:0] k;
    logic [TAG_IO_W-1:0] t;
    k = heap_key[a];
    t = heap_tag[a];
    heap_key[a] = heap_key[b];
    heap_tag[a] = heap_tag[b];
    heap_key[b] = k;
    heap_tag[b] = t;
  endfunction

  function automatic void bubble_up(int unsigned i);
    while (i > 0 && heap_key[i] < heap_key[(i - 1) / 2]) begin
      swap_nodes(i, (i - 1) / 2);
      i = (i - 1) / 2;
    end
  endfunction

  // Removes the root: the last entry takes its place and sinks down, moving
  // to the left child only when it is strictly smaller than the right one.
  function automatic void pop_root();
    int unsigned i;
    int unsigned l;
    int unsigned nxt;
    i = 0;
    heap_fill--;
    heap_key[0] = heap_key[heap_fill];
    heap_tag[0] = heap_tag[heap_fill];
    forever begin
      l = 2 * i + 1;
      if (l >= heap_fill) break;
      if (l + 1 < heap_fill) begin
        if (heap_key[i] <= heap_key[l] && heap_key[i] <= heap_key[l + 1]) break;
        nxt = (heap_key[l] < heap_key[l + 1]) ? l : l + 1;
      end else begin
        if (heap_key[i] <= heap_key[l]) break;
        nxt = l;
      end
      swap_nodes(i, nxt);
      i = nxt;
    end
  endfunction

  function automatic heap_result_t apply_heap_action(logic [ACT_W-1:0] act,
      logic [KEY_W-1:0] k, logic [TAG_IO_W-1:0] t, logic [POS_W-1:0] p);
    heap_result_t r;
    int unsigned i;
    r = '{key: '0, tag: '0, st: ST_OK, cnt: '0};
    if (act == ACT_INSERT) begin
      if (heap_fill >= HeapDepth) begin
        r.st = ST_FULL;
      end else begin
        heap_key[heap_fill] = k;
        heap_tag[heap_fill] = t;
        heap_fill++;
        bubble_up(heap_fill - 1);
        r.key = k;
        r.tag = t;
      end
    end else if (act <= ACT_DELETE) begin
      if (heap_fill == 0) begin
        r.st = ST_EMPTY;
      end else if (act == ACT_EXTRACT || act == ACT_PEEK) begin
        r.key = heap_key[0];
        r.tag = heap_tag[0];
        if (act == ACT_EXTRACT) pop_root();
      end else if (p >= heap_fill) begin
        r.st = ST_BADPOS;
      end else if (act == ACT_DECREASE) begin
        if (k > heap_key[p]) begin
          r.st = ST_RAISED;
        end else begin
          heap_key[p] = k;
          r.key = k;
          r.tag = heap_tag[p];
          bubble_up(p);
        end
      end else begin
        // Delete: the entry is carried to the root as if it held the lowest
        // key of all, then removed like an extract.
        r.key = heap_key[p];
        r.tag = heap_tag[p];
        i = p;
        while (i > 0) begin
          swap_nodes(i, (i - 1) / 2);
          i = (i - 1) / 2;
        end
        pop_root();
      end
    end
    r.cnt = heap_fill[CNT_IO_W-1:0];
    return r;
  endfunction

  // Offers one item and holds it until accepted; the prediction is made at
  // the accepting edge so that it sees the heap as the block does.
  task automatic offer_item(logic [ACT_W-1:0] act, logic [KEY_W-1:0] k,
      logic [TAG_IO_W-1:0] t, logic [POS_W-1:0] p, output heap_result_t r);
    in_valid <= 1'b1;
    action <= act;
    key_in <= k;
    tag_in <= t;
    position <= p;
    do @(posedge clk); while (!(in_ready && !timed_out));
    r = apply_heap_action(act, k, t, p);
    pending_results.push_back(r);
    status_hits[r.st]++;
    @(negedge clk);
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
  endtask

  task automatic report_mismatch(string what, longint exp_v, longint got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
  endtask

  // Output checker: every accepted result is matched to the oldest expectation.
  always @(posedge clk) begin
    heap_result_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, count", 0, entry_count);
      end else begin
        e = pending_results.pop_front();
        if (key_out !== e.key) report_mismatch("key_out", e.key, key_out);
        if (tag_out !== e.tag) report_mismatch("tag_out", e.tag, tag_out);
        if (status !== e.st) report_mismatch("status", e.st, status);
        if (entry_count !== e.cnt) report_mismatch("entry_count", e.cnt, entry_count);
      end
    end
  end

  // Receiver: random stalls on its own pattern, with one long hold-off when
  // the stimulus asks for it so that the output register and input back up.
  initial begin
    int mode;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        long_hold = 1'b0;
      end
      mode = ($time / 5000) % 4;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 1) != 0);
        default: out_ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit && !timed_out) begin
        timed_out = 1'b1;
        $display("Watchdog timeout with %0d results pending", pending_results.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  heap_row_t directed_rows[$];

  function automatic heap_row_t chk_row(logic [ACT_W-1:0] act, logic [KEY_W-1:0] k,
      logic [TAG_IO_W-1:0] t, logic [POS_W-1:0] p, status_e st,
      logic [KEY_W-1:0] ek, logic [TAG_IO_W-1:0] et, logic [CNT_IO_W-1:0] ec);
    return '{act, k, t, p, 1'b1, st, ek, et, ec};
  endfunction

  function automatic heap_row_t pred_row(logic [ACT_W-1:0] act, logic [KEY_W-1:0] k,
      logic [TAG_IO_W-1:0] t, logic [POS_W-1:0] p);
    return '{act, k, t, p, 1'b0, ST_OK, '0, '0, '0};
  endfunction

  // Picks an item biased toward a useful mix: inserts while shallow,
  // removals while deep, plus a little noise of errors and unused codes.
  task automatic random_item(output logic [ACT_W-1:0] act, output logic [KEY_W-1:0] k,
      output logic [TAG_IO_W-1:0] t, output logic [POS_W-1:0] p);
    int sel;
    sel = $urandom_range(0, 99);
    t = TAG_IO_W'($urandom);
    case ($urandom_range(0, 3))
      0: k = KEY_W'($urandom);
      1: k = KEY_W'($urandom_range(0, 15));
      2: k = {KEY_W{1'b1}} - KEY_W'($urandom_range(0, 3));
      default: k = KEY_W'($urandom_range(0, 100000));
    endcase
    p = heap_fill > 0 ? POS_W'($urandom_range(0, heap_fill - 1)) : '0;
    if (sel < 2) p = POS_W'($urandom);
    if (sel < 40 + (heap_fill < 20 ? 20 : 0)) act = ACT_INSERT;
    else if (sel < 62) act = ACT_EXTRACT;
    else if (sel < 70) act = ACT_PEEK;
    else if (sel < 85) begin
      act = ACT_DECREASE;
      if (heap_fill > 0 && sel < 82) k = KEY_W'(heap_key[p] - $urandom_range(0, 50));
      if (heap_fill > 0 && k > heap_key[p] && sel < 82) k = '0;
    end
    else if (sel < 98) act = ACT_DELETE;
    else act = ACT_W'($urandom_range(5, 7));
  endtask

  initial begin
    heap_row_t row;
    heap_result_t r;
    logic [ACT_W-1:0] act;
    logic [KEY_W-1:0] k;
    logic [TAG_IO_W-1:0] t;
    logic [POS_W-1:0] p;
    int sent;
    int burst;
    int wait_cnt;

    heap_fill = 0;
    mismatches = 0;
    results_seen = 0;
    idle_cycles = 0;
    long_hold = 1'b0;
    timed_out = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: errors on an empty heap, field extremes, every action,
    // raised and equal keys, bad positions and unused action codes.
    directed_rows = '{
      chk_row(ACT_EXTRACT, 0, 0, 0, ST_EMPTY, 0, 0, 0),
      chk_row(ACT_PEEK, 0, 0, 0, ST_EMPTY, 0, 0, 0),
      chk_row(ACT_DECREASE, 5, 0, 0, ST_EMPTY, 0, 0, 0),
      chk_row(ACT_DELETE, 0, 0, 8'hFF, ST_EMPTY, 0, 0, 0),
      chk_row(ACT_INSERT, 31'h7FFFFFFF, 16'hFFFF, 0, ST_OK, 31'h7FFFFFFF, 16'hFFFF, 1),
      chk_row(ACT_INSERT, 0, 0, 0, ST_OK, 0, 0, 2),
      chk_row(ACT_PEEK, 0, 0, 0, ST_OK, 0, 0, 2),
      chk_row(ACT_DECREASE, 1, 0, 2, ST_BADPOS, 0, 0, 2),
      chk_row(ACT_DELETE, 0, 0, 8'hFF, ST_BADPOS, 0, 0, 2),
      chk_row(ACT_DECREASE, 1, 0, 0, ST_RAISED, 0, 0, 2),
      chk_row(3'd5, 31'h7FFFFFFF, 16'hFFFF, 8'hFF, ST_OK, 0, 0, 2),
      chk_row(3'd7, 0, 0, 0, ST_OK, 0, 0, 2),
      pred_row(ACT_INSERT, 500, 16'hA5A5, 0),
      pred_row(ACT_INSERT, 500, 16'h5A5A, 0),
      pred_row(ACT_INSERT, 20, 16'h0101, 0),
      pred_row(ACT_INSERT, 7, 16'h8000, 0),
      pred_row(ACT_DECREASE, 31'h7FFFFFFF, 0, 1),
      pred_row(ACT_DECREASE, 3, 0, 5),
      pred_row(ACT_DECREASE, 3, 0, 0),
      pred_row(ACT_DELETE, 0, 0, 4),
      pred_row(ACT_DELETE, 0, 0, 0),
      pred_row(ACT_EXTRACT, 0, 0, 0),
      pred_row(ACT_EXTRACT, 0, 0, 0),
      pred_row(ACT_PEEK, 0, 0, 0)
    };
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      offer_item(row.act, row.key, row.tag, row.pos, r);
      if (row.has_exp && (r.st !== row.exp_st || r.key !== row.exp_key ||
          r.tag !== row.exp_tag || r.cnt !== row.exp_cnt))
        report_mismatch("directed row predictor", i, r.cnt);
    end
    release_input();
    // Let everything drain before the fill to capacity starts.
    while (pending_results.size() != 0) @(negedge clk);

    // Fill to capacity with long receiver hold-off; overflow, decrease, delete.
    long_hold = 1'b1;
    while (heap_fill < HeapDepth) begin
      offer_item(ACT_INSERT, KEY_W'($urandom), TAG_IO_W'($urandom), '0, r);
    end
    offer_item(ACT_INSERT, 1, 1, 0, r);
    offer_item(ACT_DECREASE, 0, 0, 8'hFF, r);
    offer_item(ACT_DELETE, 0, 0, 8'hFF, r);
    release_input();
    while (pending_results.size() != 0) @(negedge clk);

    // Random part in bursts; most bursts end in a gap, some run straight on.
    sent = 0;
    while (sent < 750) begin
      burst = $urandom_range(1, 30);
      repeat (burst) begin
        random_item(act, k, t, p);
        offer_item(act, k, t, p, r);
        sent++;
      end
      if (sent > 600 && sent < 640) begin
        release_input();
        while (pending_results.size() != 0) @(negedge clk);
      end else if ($urandom_range(0, 2) != 0) begin
        release_input();
        wait_cnt = $urandom_range(1, 40);
        repeat (wait_cnt) @(negedge clk);
      end
    end
    // Empty the heap at the end to exercise long extract runs.
    while (heap_fill > 0) offer_item(ACT_EXTRACT, 0, 0, 0, r);
    release_input();

    while (pending_results.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);

    $display("Checked %0d results; ok %0d, empty %0d, full %0d, bad position %0d, raised %0d.",
             results_seen, status_hits[ST_OK], status_hits[ST_EMPTY], status_hits[ST_FULL],
             status_hits[ST_BADPOS], status_hits[ST_RAISED]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[binary_min_heap_queue_top.f]
+incdir+sv
sv/bmhq_pkg.sv
sv/bmhq_ram.sv
sv/bmhq_ctrl.sv
sv/binary_min_heap_queue_top.sv
tb/binary_min_heap_queue_top_tb.sv
